// ----- rtl/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared widths, constants, config struct and CORDIC angle table for the
// lidar spherical projection.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int COORD_WIDTH  = 20;
  localparam int CORDIC_STEPS = 16;

  // stream widths, padded to whole bytes
  localparam int COL_W      = 21;
  localparam int ROW_W      = 20;
  localparam int S_DATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_W   = ((COL_W + ROW_W + 7) / 8) * 8;
  localparam int M_USER_W   = 2;
  localparam int USER_VIEW  = 0;
  localparam int USER_ZERO  = 1;

  // register file
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 11;
  localparam int OFFSET_W = 12;
  localparam int BEAM_W   = 17;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [IDX_W-1:0] REG_UPPER  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOWER  = 3'd4;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [OFFSET_W-1:0] offset;
    logic [BEAM_W-1:0]   upper;
    logic [BEAM_W-1:0]   lower;
  } cfg_t;

  // angles in 1/65536 rad
  localparam int ANG_W     = 20;
  localparam int PI_Q      = 205887;
  localparam int HALF_PI_Q = 102944;

  // CORDIC datapath
  localparam int CIN_W       = COORD_WIDTH + 1;
  localparam int PRESCALE_SH = 24;
  localparam int CX_W        = CIN_W + PRESCALE_SH + 3;

  // integer square root of x^2 + y^2
  localparam int SQ_W      = 2 * COORD_WIDTH + 1;
  localparam int ISQ_STEPS = COORD_WIDTH + 1;

  // column: N = W*128*(pi - az) + pi/2, divided by pi via reciprocal
  localparam int D_W      = 19;
  localparam int M_W      = WIDTH_W + D_W;
  localparam int N_W      = M_W + 8;
  localparam int Q_W      = 23;
  localparam int RECIP_SH = N_W;
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << RECIP_SH) / PI_Q);

  // latencies in register stages
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int COL_LAT    = 7;
  localparam int ROW_LAT    = ROW_W + 4;
  localparam int COL_PAD    = ROW_LAT - COL_LAT;
  localparam int TOTAL_LAT  = 3 + ISQ_STEPS + CORDIC_LAT + ROW_LAT;

  function automatic logic signed [ANG_W-1:0] angle_step(input int i);
    case (i)
      0:  return ANG_W'(51472);
      1:  return ANG_W'(30386);
      2:  return ANG_W'(16055);
      3:  return ANG_W'(8150);
      4:  return ANG_W'(4091);
      5:  return ANG_W'(2047);
      6:  return ANG_W'(1024);
      7:  return ANG_W'(512);
      8:  return ANG_W'(256);
      9:  return ANG_W'(128);
      10: return ANG_W'(64);
      11: return ANG_W'(32);
      12: return ANG_W'(16);
      13: return ANG_W'(8);
      14: return ANG_W'(4);
      15: return ANG_W'(2);
      16: return ANG_W'(1);
      default: return '0;
    endcase
  endfunction

endpackage

// ----- rtl/lidar_spherical_projection.sv -----
// ----------------------------------------------------------------------------
// lidar_spherical_projection
// Projects a 3-D lidar point onto range-image column and row, 8 fraction
// bits each, with in-view and zero-range flags.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  s_*       in   tvalid/tready    point_x, point_y, point_z
//  m_*       out  tvalid/tready    column, row; tuser in_view, zero_range
//  apb       in   psel/penable     five config registers at 4*i
//
// One request is accepted per clock while the output is not stalled.
// Depth is set by the 21-stage square root, the 16-iteration CORDICs and
// the 20-bit restoring divider for the row.
// Reset is synchronous; it clears the valid chain and loads the config register defaults.
// The whole pipeline advances together: a stalled output holds every stage.
// ----------------------------------------------------------------------------
module lidar_spherical_projection (
  input  logic                          clk,
  input  logic                          rst,
  // point_x [19:0], point_y [39:20], point_z [59:40]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lsp_pkg::S_DATA_W-1:0]  s_tdata,
  // column [20:0], row [40:21]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lsp_pkg::M_DATA_W-1:0]  m_tdata,
  // in_view [0], zero_range [1]
  output logic [lsp_pkg::M_USER_W-1:0]  m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsp_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lsp_pkg::*;

  localparam int XD = 2 + ISQ_STEPS;

  // ---------------- config registers ----------------
  cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WIDTH_W'(1024);
      cfg.height <= HEIGHT_W'(128);
      cfg.offset <= OFFSET_W'(12);
      cfg.upper  <= BEAM_W'(24306);
      cfg.lower  <= BEAM_W'(24455);
    end else if (psel && penable && pwrite) begin
      case (paddr[ADDR_W-1:2])
        REG_WIDTH:  cfg.width  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[HEIGHT_W-1:0];
        REG_OFFSET: cfg.offset <= pwdata[OFFSET_W-1:0];
        REG_UPPER:  cfg.upper  <= pwdata[BEAM_W-1:0];
        REG_LOWER:  cfg.lower  <= pwdata[BEAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_WIDTH:  prdata = 32'(cfg.width);
      REG_HEIGHT: prdata = 32'(cfg.height);
      REG_OFFSET: prdata = 32'(cfg.offset);
      REG_UPPER:  prdata = 32'(cfg.upper);
      REG_LOWER:  prdata = 32'(cfg.lower);
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // global advance: the output register is free or being drained
  logic en, acc;
  logic [TOTAL_LAT-1:0] vld, zr;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && en;
  assign m_tvalid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst)     vld <= '0;
    else if (en) vld <= {vld[TOTAL_LAT-2:0], acc};
  end

  // zero-range flag rides alongside the valid chain
  always_ff @(posedge clk) begin
    if (en) zr <= {zr[TOTAL_LAT-2:0], s_tdata[3*COORD_WIDTH-1:0] == '0};
  end

  // ---------------- stage 1..3: squares and sum ----------------
  logic signed [COORD_WIDTH-1:0] xd [0:XD];
  logic signed [COORD_WIDTH-1:0] yd [0:XD];
  logic signed [COORD_WIDTH-1:0] zd [0:XD];
  logic [COORD_WIDTH-1:0]        ax, ay;
  logic [2*COORD_WIDTH-1:0]      sqx, sqy;
  logic [SQ_W-1:0]               sq_sum;

  assign ax = xd[0][COORD_WIDTH-1] ? COORD_WIDTH'(-xd[0]) : COORD_WIDTH'(xd[0]);
  assign ay = yd[0][COORD_WIDTH-1] ? COORD_WIDTH'(-yd[0]) : COORD_WIDTH'(yd[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      xd[0]  <= s_tdata[COORD_WIDTH-1:0];
      yd[0]  <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      zd[0]  <= s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
      sqx    <= (2*COORD_WIDTH)'(ax) * (2*COORD_WIDTH)'(ax);
      sqy    <= (2*COORD_WIDTH)'(ay) * (2*COORD_WIDTH)'(ay);
      sq_sum <= SQ_W'(sqx) + SQ_W'(sqy);
      for (int k = 0; k < XD; k++) begin
        xd[k+1] <= xd[k];
        yd[k+1] <= yd[k];
        zd[k+1] <= zd[k];
      end
    end
  end

  // ---------------- horizontal range ----------------
  logic [COORD_WIDTH-1:0] lxy;

  lsp_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .n    (sq_sum),
    .root (lxy)
  );

  // ---------------- azimuth and elevation ----------------
  logic signed [ANG_W-1:0] az, el;

  lsp_cordic u_cordic_az (
    .clk   (clk),
    .en    (en),
    .in_x  (CIN_W'(xd[XD])),
    .in_y  (CIN_W'(yd[XD])),
    .angle (az)
  );

  lsp_cordic u_cordic_el (
    .clk   (clk),
    .en    (en),
    .in_x  ($signed({1'b0, lxy})),
    .in_y  (CIN_W'(zd[XD])),
    .angle (el)
  );

  // ---------------- column and row ----------------
  logic [COL_W-1:0]        col_raw;
  logic [COL_W-1:0]        col_d [0:COL_PAD-1];
  logic signed [ROW_W-1:0] row;
  logic                    in_view;

  lsp_column u_column (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .az     (az),
    .column (col_raw)
  );

  lsp_row u_row (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .el      (el),
    .row     (row),
    .in_view (in_view)
  );

  // column path is shorter; line it up with the row
  always_ff @(posedge clk) begin
    if (en) begin
      col_d[0] <= col_raw;
      for (int k = 1; k < COL_PAD; k++) col_d[k] <= col_d[k-1];
    end
  end

  assign m_tdata = M_DATA_W'({row, col_d[COL_PAD-1]});
  assign m_tuser = {zr[TOTAL_LAT-1], in_view};

`ifndef SYNTHESIS
  // an in-view row is never negative
  a_view_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_VIEW] |-> !m_tdata[COL_W+ROW_W-1])
    else $error("in_view set on a negative row");

  // zero height leaves nothing in view
  a_view_height: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_VIEW] |-> cfg.height != '0)
    else $error("in_view set with zero height");

  // origin point has zero elevation, so its row cannot be negative
  a_zero_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_ZERO] |-> !m_tdata[COL_W+ROW_W-1])
    else $error("zero-range point gave negative row");

  // a stall freezes the valid chain
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid chain moved during stall");
`endif

endmodule

// ----- rtl/lsp_isqrt.sv -----
// ----------------------------------------------------------------------------
// lsp_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lsp_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [lsp_pkg::SQ_W-1:0]         n,
  output logic [lsp_pkg::COORD_WIDTH-1:0]  root
);
  import lsp_pkg::*;

  logic [SQ_W-1:0] ns [1:ISQ_STEPS];
  logic [SQ_W-1:0] rs [1:ISQ_STEPS];

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [SQ_W-1:0] n_in, r_in, trial;
    if (k == 0) begin : g_first
      assign n_in = n;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = ns[k];
      assign r_in = rs[k];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          ns[k+1] <= n_in - trial;
          rs[k+1] <= (r_in >> 1) + BIT;
        end else begin
          ns[k+1] <= n_in;
          rs[k+1] <= r_in >> 1;
        end
      end
    end
  end

  assign root = rs[ISQ_STEPS][COORD_WIDTH-1:0];

endmodule

// ----- rtl/lsp_cordic.sv -----
// ----------------------------------------------------------------------------
// lsp_cordic
// Vectoring CORDIC atan2(y, x), one iteration per stage, result clamped
// to [-pi, pi]; zero vector gives zero.
// ----------------------------------------------------------------------------
module lsp_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [lsp_pkg::CIN_W-1:0]  in_x,
  input  logic signed [lsp_pkg::CIN_W-1:0]  in_y,
  output logic signed [lsp_pkg::ANG_W-1:0]  angle
);
  import lsp_pkg::*;

  localparam logic signed [ANG_W-1:0] PI_A   = ANG_W'(PI_Q);
  localparam logic signed [ANG_W-1:0] HALF_A = ANG_W'(HALF_PI_Q);

  logic signed [CX_W-1:0]  cx [0:CORDIC_STEPS];
  logic signed [CX_W-1:0]  cy [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] ca [0:CORDIC_STEPS];
  logic                    cz [0:CORDIC_STEPS];

  logic signed [CX_W-1:0]  px, py, fx, fy;
  logic signed [ANG_W-1:0] fa;

  assign px = CX_W'(in_x) <<< PRESCALE_SH;
  assign py = CX_W'(in_y) <<< PRESCALE_SH;

  // fold the left half plane by a quarter turn
  always_comb begin
    fx = px;
    fy = py;
    fa = '0;
    if (px < 0) begin
      if (py >= 0) begin
        fx = py;
        fy = -px;
        fa = HALF_A;
      end else begin
        fx = -py;
        fy = px;
        fa = -HALF_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= fx;
      cy[0] <= fy;
      ca[0] <= fa;
      cz[0] <= (in_x == '0) && (in_y == '0);
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic signed [CX_W-1:0] sx, sy;
    assign sx = cx[k] >>> k;
    assign sy = cy[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        cz[k+1] <= cz[k];
        if (cy[k] < 0) begin
          cx[k+1] <= cx[k] - sy;
          cy[k+1] <= cy[k] + sx;
          ca[k+1] <= ca[k] - angle_step(k);
        end else begin
          cx[k+1] <= cx[k] + sy;
          cy[k+1] <= cy[k] - sx;
          ca[k+1] <= ca[k] + angle_step(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cz[CORDIC_STEPS])              angle <= '0;
      else if (ca[CORDIC_STEPS] > PI_A)  angle <= PI_A;
      else if (ca[CORDIC_STEPS] < -PI_A) angle <= -PI_A;
      else                               angle <= ca[CORDIC_STEPS];
    end
  end

endmodule

// ----- rtl/lsp_column.sv -----
// ----------------------------------------------------------------------------
// lsp_column
// Azimuth to column: W*128*(pi - az)/pi rounded, plus offset, one wrap.
// Division by pi is a split reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module lsp_column (
  input  logic                              clk,
  input  logic                              en,
  input  lsp_pkg::cfg_t                     cfg,
  input  logic signed [lsp_pkg::ANG_W-1:0]  az,
  output logic [lsp_pkg::COL_W-1:0]         column
);
  import lsp_pkg::*;

  localparam int AW1  = ANG_W + 1;
  localparam int HALF = N_W / 2;
  localparam int P_W  = HALF + Q_W;
  localparam int QP_W = Q_W + D_W - 1;
  localparam int C_W  = Q_W + 1;
  localparam logic [N_W-1:0] RND = N_W'(PI_Q / 2);

  logic signed [AW1-1:0] dd;
  logic [D_W-1:0]        d;
  assign dd = AW1'(ANG_W'(PI_Q)) - AW1'(az);
  assign d  = dd[D_W-1:0];

  // c1: W * (pi - az)
  logic [M_W-1:0] m1;
  // c2: dividend
  logic [N_W-1:0] n2, n3, n4, n5;
  // c3: partial products with the reciprocal
  logic [P_W-1:0] p_hi, p_lo;
  // c4: estimate, c5: back-multiply
  logic [Q_W-1:0]  q4, q5;
  logic [QP_W-1:0] qp5;
  // c6: corrected quotient plus offset
  logic [C_W-1:0]  c6, c7;
  logic [N_W:0]    rem;
  logic [63:0]     psum;

  assign psum = (64'(p_hi) << HALF) + 64'(p_lo);
  assign rem  = {1'b0, n5} - (N_W+1)'(qp5);

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= M_W'(cfg.width) * M_W'(d);
      n2   <= {m1, 7'b0} + RND;
      p_hi <= P_W'(n2[N_W-1:HALF]) * P_W'(RECIP);
      p_lo <= P_W'(n2[HALF-1:0]) * P_W'(RECIP);
      n3   <= n2;
      q4   <= psum[RECIP_SH +: Q_W];
      n4   <= n3;
      qp5  <= QP_W'(q4) * QP_W'(PI_Q);
      q5   <= q4;
      n5   <= n4;
      c6   <= C_W'(q5) + C_W'(rem >= (N_W+1)'(PI_Q)) + (C_W'(cfg.offset) << 8);
      if (c6 > C_W'({cfg.width, 8'b0})) c7 <= c6 - C_W'({cfg.width, 8'b0});
      else                               c7 <= c6;
    end
  end

  assign column = c7[COL_W-1:0];

endmodule

// ----- rtl/lsp_row.sv -----
// ----------------------------------------------------------------------------
// lsp_row
// Elevation to row: (upper - el)*H*256/(upper + lower), rounded half away
// from zero, saturated. Restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsp_row (
  input  logic                              clk,
  input  logic                              en,
  input  lsp_pkg::cfg_t                     cfg,
  input  logic signed [lsp_pkg::ANG_W-1:0]  el,
  output logic signed [lsp_pkg::ROW_W-1:0]  row,
  output logic                              in_view
);
  import lsp_pkg::*;

  localparam int DIF_W = ANG_W + 1;
  localparam int PRD_W = DIF_W + HEIGHT_W + 1;
  localparam int MAG_W = PRD_W + 8;
  localparam int DEN_W = BEAM_W + 1;
  localparam int LIM_W = HEIGHT_W + 9;
  localparam logic signed [ROW_W-1:0] RMAX = {1'b0, {(ROW_W-1){1'b1}}};
  localparam logic signed [ROW_W-1:0] RMIN = {1'b1, {(ROW_W-1){1'b0}}};

  logic [DEN_W-1:0]        den;
  logic signed [DIF_W-1:0] diff;
  logic signed [PRD_W-1:0] prod;
  logic signed [MAG_W-1:0] num;
  logic [MAG_W-1:0]        mag, d2;
  logic                    neg2, nz2;

  assign den  = DEN_W'(cfg.upper) + DEN_W'(cfg.lower);
  assign diff = $signed(DIF_W'(cfg.upper)) - DIF_W'(el);
  assign num  = {prod, 8'b0};
  assign mag  = (num < 0) ? MAG_W'(-num) : MAG_W'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= diff * $signed({1'b0, cfg.height});
      d2   <= mag + MAG_W'(den >> 1);
      neg2 <= prod < 0;
      nz2  <= prod != '0;
    end
  end

  // divider stages
  logic [MAG_W-1:0] rem [0:ROW_W];
  logic [ROW_W-1:0] quo [0:ROW_W];
  logic             ovf [0:ROW_W];
  logic             neg [0:ROW_W];
  logic             nz  [0:ROW_W];
  logic             dz  [0:ROW_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= d2;
      quo[0] <= '0;
      ovf[0] <= d2 >= (MAG_W'(den) << ROW_W);
      neg[0] <= neg2;
      nz[0]  <= nz2;
      dz[0]  <= den == '0;
    end
  end

  for (genvar k = 0; k < ROW_W; k++) begin : g_div
    localparam int SH = ROW_W - 1 - k;
    logic [MAG_W-1:0] dsh;
    assign dsh = MAG_W'(den) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        ovf[k+1] <= ovf[k];
        neg[k+1] <= neg[k];
        nz[k+1]  <= nz[k];
        dz[k+1]  <= dz[k];
        if (rem[k] >= dsh) begin
          rem[k+1] <= rem[k] - dsh;
          quo[k+1] <= quo[k] | (ROW_W'(1) << SH);
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
      end
    end
  end

  logic signed [ROW_W-1:0] rv;
  logic signed [LIM_W-1:0] lim;
  logic [ROW_W-1:0]        qf;

  assign qf  = quo[ROW_W];
  assign lim = $signed({1'b0, cfg.height, 8'b0}) - LIM_W'(256);

  always_comb begin
    if (dz[ROW_W] && !nz[ROW_W])            rv = '0;
    else if (ovf[ROW_W] || qf[ROW_W-1])     rv = neg[ROW_W] ? RMIN : RMAX;
    else if (neg[ROW_W])                    rv = -$signed(qf);
    else                                    rv = $signed(qf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row     <= rv;
      in_view <= !rv[ROW_W-1] && (LIM_W'(rv) <= lim);
    end
  end

endmodule

// ----- tb/lidar_spherical_projection_tb.sv -----
// ----------------------------------------------------------------------------
// lidar_spherical_projection_tb
// Streams lidar points through the projection block and checks every column,
// row and flag against a bit-true fixed-point predictor held in the bench.
// Covers register settings at their extremes, back-pressure and input gaps.
// ----------------------------------------------------------------------------
module lidar_spherical_projection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsp_pkg::*;

  localparam longint PI_FX   = 205887;
  localparam longint HPI_FX  = 102944;
  localparam longint ROW_TOP = 524287;
  localparam longint ROW_BOT = -524288;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             in_view;
    logic             zero_range;
  } pixel_t;

  // projection scoreboard: predicts one pixel per accepted point
  class pixel_board;
    pixel_t   pending[$];
    int       errors;
    longint   width, height, offset, upper, lower;

    function void reset_regs();
      width = 1024; height = 128; offset = 12; upper = 24306; lower = 24455;
      errors = 0;
    endfunction

    function longint isqrt(longint n);
      longint res, bit_v;
      res = 0;
      bit_v = 64'sd1 <<< 62;
      while (bit_v > n) bit_v = bit_v >>> 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n = n - res - bit_v;
          res = (res >>> 1) + bit_v;
        end else begin
          res = res >>> 1;
        end
        bit_v = bit_v >>> 2;
      end
      return res;
    endfunction

    // vectoring CORDIC, shifts floor toward minus infinity (>>> on signed)
    function longint vector_angle(longint y, longint x);
      longint a, t, nx, ny;
      a = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 16777216;
      y = y * 16777216;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; a = HPI_FX;
        end else begin
          t = x; x = -y; y = t; a = -HPI_FX;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y < 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); a = a - angle_step(i);
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); a = a + angle_step(i);
        end
        x = nx; y = ny;
      end
      if (a > PI_FX) a = PI_FX;
      if (a < -PI_FX) a = -PI_FX;
      return a;
    endfunction

    function void note_point(logic signed [COORD_WIDTH-1:0] px, py, pz);
      longint x, y, z, az, el, num, den, mag, q, row, col, wq, lxy;
      bit origin;
      pixel_t p;
      x = px; y = py; z = pz;
      origin = (x == 0 && y == 0 && z == 0);
      az = vector_angle(y, x);
      col = (width * 128 * (PI_FX - az) + PI_FX / 2) / PI_FX + offset * 256;
      wq = width * 256;
      if (col > wq) col = col - wq;
      lxy = isqrt(x * x + y * y);
      el = origin ? 0 : vector_angle(z, lxy);
      num = (upper - el) * height * 256;
      den = upper + lower;
      if (den == 0) begin
        row = num > 0 ? ROW_TOP : (num < 0 ? ROW_BOT : 0);
      end else begin
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        row = num < 0 ? -q : q;
        if (row > ROW_TOP) row = ROW_TOP;
        if (row < ROW_BOT) row = ROW_BOT;
      end
      p.column = col[COL_W-1:0];
      p.row = row[ROW_W-1:0];
      p.in_view = (row >= 0 && row <= height * 256 - 256);
      p.zero_range = origin;
      pending = {pending, p};
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel %h", $realtime, got);
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      if (got.column !== exp_p.column) begin
        $display("%0t: column exp %0d got %0d", $realtime, exp_p.column, got.column);
        errors++;
      end
      if (got.row !== exp_p.row) begin
        $display("%0t: row exp %0d got %0d", $realtime,
                 $signed(exp_p.row), $signed(got.row));
        errors++;
      end
      if (got.in_view !== exp_p.in_view) begin
        $display("%0t: in_view exp %0d got %0d", $realtime, exp_p.in_view, got.in_view);
        errors++;
      end
      if (got.zero_range !== exp_p.zero_range) begin
        $display("%0t: zero_range exp %0d got %0d", $realtime,
                 exp_p.zero_range, got.zero_range);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;  // point_x, point_y, point_z from bit 0
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [M_DATA_W-1:0]  m_tdata;       // column, row from bit 0
  logic [M_USER_W-1:0]  m_tuser;       // in_view, zero_range from bit 0
  logic                 psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  pixel_board board = new();
  bit         sink_on = 0;     // receiver active
  int         hold_off = 0;    // long back-pressure stretch, in cycles

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  lidar_spherical_projection DUT (.*);

  // every accepted request is predicted at the edge that takes it
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      board.note_point(s_tdata[19:0], s_tdata[39:20], s_tdata[59:40]);
    if (!rst && m_tvalid && m_tready)
      board.check_pixel({m_tdata[20:0], m_tdata[40:21], m_tuser[USER_VIEW],
                         m_tuser[USER_ZERO]});
  end

  // receiver: random stalls before each pixel, plus a long hold-off
  initial begin
    int gap;
    wait (sink_on);
    forever begin
      if (hold_off > 0) begin
        m_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_WIDTH:  board.width  = val[WIDTH_W-1:0];
      REG_HEIGHT: board.height = val[HEIGHT_W-1:0];
      REG_OFFSET: board.offset = val[OFFSET_W-1:0];
      REG_UPPER:  board.upper  = val[BEAM_W-1:0];
      default:    board.lower  = val[BEAM_W-1:0];
    endcase
  endtask

  task automatic apply_setting(input int w, h, o, u, l);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_OFFSET, o);
    reg_write(REG_UPPER, u);
    reg_write(REG_LOWER, l);
  endtask

  // one point, with a random gap in front unless told not to
  task automatic send_point(input logic [19:0] x, y, z, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'b0, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 8) @(posedge clk);
  endtask

  // mostly realistic scan geometry, sometimes full-range noise
  task automatic random_point(input bit no_gap = 0);
    logic [19:0] x, y, z;
    int k;
    k = $urandom_range(0, 9);
    x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
    if (k < 6) begin
      x = 20'($signed(20'($urandom_range(0, 40000))) - 20000);
      y = 20'($signed(20'($urandom_range(0, 40000))) - 20000);
      z = 20'($signed(20'($urandom_range(0, 8000))) - 4000);
    end else if (k == 6) begin
      x = '0; y = '0;
    end else if (k == 7) begin
      x = 20'($urandom_range(0, 3));
      y = 20'($urandom_range(0, 3));
      z = 20'($urandom_range(0, 3));
    end
    send_point(x, y, z, no_gap);
  endtask

  initial begin
    int settings[6][5] = '{
      '{1024, 128, 12, 24306, 24455},
      '{1, 1, 0, 0, 0},
      '{4096, 1024, 4095, 102944, 102944},
      '{0, 0, 4095, 131071, 131071},
      '{8191, 2047, 100, 0, 102944},
      '{360, 64, 0, 30000, 1}};
    logic [19:0] ext[5] = '{20'h80000, 20'h7FFFF, 20'h00000, 20'hFFFFF, 20'h00001};
    board.reset_regs();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    sink_on = 1;

    // directed: extremes, vertical axis, axis points, reset registers
    foreach (ext[i]) foreach (ext[j]) send_point(ext[i], ext[j], ext[(i + j) % 5]);
    drain();

    for (int s = 1; s < 6; s++) begin
      apply_setting(settings[s][0], settings[s][1], settings[s][2],
                    settings[s][3], settings[s][4]);
      for (int n = 0; n < 120; n++) random_point();
      drain();
    end

    // back-pressure: long receiver hold-off while points keep coming
    apply_setting(720, 32, 7, 20000, 20000);
    hold_off = 150;
    for (int n = 0; n < 200; n++) random_point(1);
    // sender pauses until everything has come back
    drain();

    for (int r = 0; r < 5; r++) begin
      apply_setting($urandom_range(1, 4096), $urandom_range(1, 1024),
                    $urandom_range(0, 4095), $urandom_range(0, 102944),
                    $urandom_range(0, 102944));
      for (int n = 0; n < 200; n++) random_point();
      drain();
    end

    if (board.errors == 0)
      $display("lidar_spherical_projection verification clean");
    else
      $display("lidar_spherical_projection verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("lidar_spherical_projection verification failed");
    $finish;
  end
endmodule
